// File: rtl/mgd_pkg.sv
// ----------------------------------------------------------------------------
// mgd_pkg
// Shared types, constants and lookup tables of the 2D Mahalanobis gate.
// ----------------------------------------------------------------------------
`default_nettype none

package mgd_pkg;

   localparam logic [31:0] NOISE_RESET = 32'd377487;
   localparam logic [31:0] GATE_RESET  = 32'd1048576;

   localparam logic REG_NOISE = 1'b0;
   localparam logic REG_GATE  = 1'b1;

   localparam int QUOT_BITS      = 32;
   localparam int STEPS_PER_STG  = 2;
   localparam int DIV_STAGES     = QUOT_BITS / STEPS_PER_STG;

   // floor(x/6) == (x*RECIP6)>>16 for x below 2^12
   localparam logic [13:0] RECIP6 = 14'd10923;
   localparam logic [4:0]  LIK_INT_LIMIT = 5'd24;

   // input item, first field in the highest bits
   typedef struct packed {
      logic signed [31:0] meas_y;
      logic signed [31:0] meas_x;
      logic signed [31:0] cov_yy;
      logic signed [31:0] cov_yx;
      logic signed [31:0] cov_xy;
      logic signed [31:0] cov_xx;
      logic signed [31:0] track_y;
      logic signed [31:0] track_x;
   } req_type;

   // one divider lane: partial remainder, dividend bits still to shift in, divisor, quotient, flags
   typedef struct packed {
      logic [64:0] rem;
      logic [31:0] nlo;
      logic [63:0] dv;
      logic [31:0] quo;
      logic        sat;
      logic        sing;
   } div_type;

   function automatic div_type div_step(input div_type d);
      div_type     r;
      logic [64:0] sh;
      logic        ge;
      r   = d;
      sh  = {d.rem[63:0], d.nlo[31]};
      ge  = (sh >= {1'b0, d.dv});
      r.rem = ge ? (sh - {1'b0, d.dv}) : sh;
      r.nlo = {d.nlo[30:0], 1'b0};
      r.quo = {d.quo[30:0], ge};
      return r;
   endfunction

   // exp(-i/2) in Q1.24
   function automatic logic [24:0] exp_half(input logic [4:0] i);
      logic [24:0] v;
      unique case (i)
         5'd0:  v = 25'd16777216;
         5'd1:  v = 25'd10175896;
         5'd2:  v = 25'd6171993;
         5'd3:  v = 25'd3743503;
         5'd4:  v = 25'd2270549;
         5'd5:  v = 25'd1377158;
         5'd6:  v = 25'd835288;
         5'd7:  v = 25'd506628;
         5'd8:  v = 25'd307285;
         5'd9:  v = 25'd186378;
         5'd10: v = 25'd113044;
         5'd11: v = 25'd68565;
         5'd12: v = 25'd41587;
         5'd13: v = 25'd25224;
         5'd14: v = 25'd15299;
         5'd15: v = 25'd9279;
         5'd16: v = 25'd5628;
         5'd17: v = 25'd3414;
         5'd18: v = 25'd2070;
         5'd19: v = 25'd1256;
         5'd20: v = 25'd762;
         5'd21: v = 25'd462;
         5'd22: v = 25'd280;
         5'd23: v = 25'd170;
         default: v = 25'd0;
      endcase
      return v;
   endfunction

   // exp(-k/16) in Q1.24
   function automatic logic [24:0] exp_frac(input logic [2:0] k);
      logic [24:0] v;
      unique case (k)
         3'd0: v = 25'd16777216;
         3'd1: v = 25'd15760736;
         3'd2: v = 25'd14805841;
         3'd3: v = 25'd13908801;
         3'd4: v = 25'd13066109;
         3'd5: v = 25'd12274473;
         3'd6: v = 25'd11530801;
         default: v = 25'd10832185;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// File: rtl/mgd_quad.sv
// ----------------------------------------------------------------------------
// mgd_quad
// Residuals, innovation covariance, determinant and quadratic form; sets up
// the dividend for the quotient pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module mgd_quad (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            adv,
   input  wire logic            in_valid,
   input  wire mgd_pkg::req_type in_item,
   input  wire logic [31:0]     noise,
   output logic                 out_valid,
   output mgd_pkg::div_type     out_item
);

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;

   // stage 1: residuals and saturated diagonal
   logic signed [32:0] rx_in, ry_in, off_in, rx_ff, ry_ff, off_ff;
   logic signed [31:0] sxx_in, syy_in, sxx_ff, syy_ff, sxy_ff, syx_ff;
   logic signed [33:0] dxx, dyy;

   always_comb begin
      rx_in  = $signed({in_item.meas_x[31], in_item.meas_x})
             - $signed({in_item.track_x[31], in_item.track_x});
      ry_in  = $signed({in_item.meas_y[31], in_item.meas_y})
             - $signed({in_item.track_y[31], in_item.track_y});
      off_in = $signed({in_item.cov_xy[31], in_item.cov_xy})
             + $signed({in_item.cov_yx[31], in_item.cov_yx});
      dxx = $signed({{2{in_item.cov_xx[31]}}, in_item.cov_xx}) + $signed({2'b00, noise});
      dyy = $signed({{2{in_item.cov_yy[31]}}, in_item.cov_yy}) + $signed({2'b00, noise});
      sxx_in = (!dxx[33] && dxx[32:31] != 2'b00) ? 32'sh7FFFFFFF : dxx[31:0];
      syy_in = (!dyy[33] && dyy[32:31] != 2'b00) ? 32'sh7FFFFFFF : dyy[31:0];
   end

   // stage 2: first products
   logic signed [64:0] a1_in, a3_in, a1_ff, a3_ff;
   logic signed [65:0] a2_in, a2_ff;
   logic signed [63:0] p1_in, p2_in, p1_ff, p2_ff;
   logic signed [32:0] rx2_ff, ry2_ff;

   assign a1_in = syy_ff * rx_ff;
   assign a2_in = off_ff * ry_ff;
   assign a3_in = sxx_ff * ry_ff;
   assign p1_in = sxx_ff * syy_ff;
   assign p2_in = sxy_ff * syx_ff;

   // stage 3: partial products of the second multiply, determinant
   logic signed [65:0] m1l_in, m1h_in, m3l_in, m3h_in, m2l_in;
   logic signed [66:0] m2h_in;
   logic signed [65:0] m1l_ff, m1h_ff, m3l_ff, m3h_ff, m2l_ff;
   logic signed [66:0] m2h_ff;
   logic signed [64:0] det_in, det3_ff;

   assign m1l_in = $signed({1'b0, a1_ff[31:0]}) * rx2_ff;
   assign m1h_in = $signed(a1_ff[64:32]) * rx2_ff;
   assign m2l_in = $signed({1'b0, a2_ff[31:0]}) * rx2_ff;
   assign m2h_in = $signed(a2_ff[65:32]) * rx2_ff;
   assign m3l_in = $signed({1'b0, a3_ff[31:0]}) * ry2_ff;
   assign m3h_in = $signed(a3_ff[64:32]) * ry2_ff;
   assign det_in = $signed({p1_ff[63], p1_ff}) - $signed({p2_ff[63], p2_ff});

   // stage 4: recombine terms
   logic signed [103:0] t1_in, t2_in, t3_in, t1_ff, t2_ff, t3_ff;
   logic signed [64:0]  det4_ff;

   assign t1_in = $signed({m1h_ff, 32'd0}) + m1l_ff;
   assign t2_in = $signed({m2h_ff, 32'd0}) + m2l_ff;
   assign t3_in = $signed({m3h_ff, 32'd0}) + m3l_ff;

   // stage 5: quadratic form
   logic signed [103:0] n_in, n_ff;
   logic signed [64:0]  det5_ff;

   assign n_in = t1_ff - t2_ff + t3_ff;

   // stage 6: saturation test and divider setup
   logic [111:0] big_n;
   logic [111:0] big_d;
   always_comb begin
      big_n = {n_ff[103:0], 8'd0};
      big_d = {16'd0, det5_ff[63:0], 32'd0};
   end

   mgd_pkg::div_type d_in, d_ff;
   always_comb begin
      d_in.rem  = big_n[96:32];
      d_in.nlo  = big_n[31:0];
      d_in.dv   = det5_ff[63:0];
      d_in.quo  = '0;
      d_in.sing = det5_ff[64] || (det5_ff == '0);
      d_in.sat  = n_ff[103] || (big_n >= big_d);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rx_ff   <= rx_in;
         ry_ff   <= ry_in;
         off_ff  <= off_in;
         sxx_ff  <= sxx_in;
         syy_ff  <= syy_in;
         sxy_ff  <= in_item.cov_xy;
         syx_ff  <= in_item.cov_yx;
         a1_ff   <= a1_in;
         a2_ff   <= a2_in;
         a3_ff   <= a3_in;
         p1_ff   <= p1_in;
         p2_ff   <= p2_in;
         rx2_ff  <= rx_ff;
         ry2_ff  <= ry_ff;
         m1l_ff  <= m1l_in;
         m1h_ff  <= m1h_in;
         m2l_ff  <= m2l_in;
         m2h_ff  <= m2h_in;
         m3l_ff  <= m3l_in;
         m3h_ff  <= m3h_in;
         det3_ff <= det_in;
         t1_ff   <= t1_in;
         t2_ff   <= t2_in;
         t3_ff   <= t3_in;
         det4_ff <= det3_ff;
         n_ff    <= n_in;
         det5_ff <= det4_ff;
         d_ff    <= d_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_item  = d_ff;

endmodule

`default_nettype wire

// File: rtl/mgd_div.sv
// ----------------------------------------------------------------------------
// mgd_div
// Pipelined restoring divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mgd_div (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            adv,
   input  wire logic            in_valid,
   input  wire mgd_pkg::div_type in_item,
   output logic                 out_valid,
   output mgd_pkg::div_type     out_item
);

   mgd_pkg::div_type stg_ff [mgd_pkg::DIV_STAGES];
   mgd_pkg::div_type stg_in [mgd_pkg::DIV_STAGES];
   logic [mgd_pkg::DIV_STAGES-1:0] vld_ff;

   always_comb begin
      mgd_pkg::div_type src;
      for (int s = 0; s < mgd_pkg::DIV_STAGES; s++) begin
         src = (s == 0) ? in_item : stg_ff[(s == 0) ? 0 : s - 1];
         for (int b = 0; b < mgd_pkg::STEPS_PER_STG; b++) begin
            src = mgd_pkg::div_step(src);
         end
         stg_in[s] = src;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[mgd_pkg::DIV_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < mgd_pkg::DIV_STAGES; s++) begin
            stg_ff[s] <= stg_in[s];
         end
      end
   end

   assign out_valid = vld_ff[mgd_pkg::DIV_STAGES-1];
   assign out_item  = stg_ff[mgd_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

// File: rtl/mgd_lik.sv
// ----------------------------------------------------------------------------
// mgd_lik
// Distance saturation, gate compare and exp(-d/2) by table and series.
// ----------------------------------------------------------------------------
`default_nettype none

module mgd_lik (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            adv,
   input  wire logic            in_valid,
   input  wire mgd_pkg::div_type in_item,
   input  wire logic [31:0]     gate,
   output logic                 out_valid,
   output logic [31:0]          distance,
   output logic [16:0]          likelihood,
   output logic                 in_gate,
   output logic                 singular
);

   typedef struct packed {
      logic [31:0] dval;
      logic        inr;
      logic        gin;
      logic        sing;
      logic [19:0] u;
   } lane_type;

   logic [5:0] v_ff;

   // L1: distance
   lane_type    l1_in, l1_ff, l2_ff, l3_ff, l4_ff, l5_ff;
   logic [31:0] dist_w;
   always_comb begin
      dist_w     = (in_item.sing || in_item.sat) ? 32'hFFFFFFFF : in_item.quo;
      l1_in.dval = dist_w;
      l1_in.inr  = (dist_w[31:16] < {11'd0, mgd_pkg::LIK_INT_LIMIT});
      l1_in.gin  = !in_item.sing && (dist_w < gate);
      l1_in.sing = in_item.sing;
      l1_in.u    = {dist_w[12:0], 7'd0};
   end

   // L2: u^2 and table product
   logic [39:0] uu;
   logic [49:0] abw;
   logic [15:0] u2_in, u2_ff, u2b_ff;
   logic [24:0] ab_in, ab_ff, ab3_ff;
   always_comb begin
      uu    = l1_ff.u * l1_ff.u;
      abw   = mgd_pkg::exp_half(l1_ff.dval[20:16]) * mgd_pkg::exp_frac(l1_ff.dval[15:13]);
      u2_in = uu[39:24];
      ab_in = abw[48:24];
   end

   // L3: u^3
   logic [35:0] uuu;
   logic [11:0] u3_in, u3_ff;
   always_comb begin
      uuu   = u2_ff * l2_ff.u;
      u3_in = uuu[35:24];
   end

   // L4: series 1 - u + u^2/2 - u^3/6
   logic [25:0] q6w;
   logic [24:0] p_in, p_ff, ab4_ff;
   always_comb begin
      q6w  = u3_ff * mgd_pkg::RECIP6;
      p_in = 25'd16777216 - {5'd0, l3_ff.u} + {10'd0, u2b_ff[15:1]} - {15'd0, q6w[25:16]};
   end

   // L5: scale by table value
   logic [49:0] tw;
   logic [24:0] t_in, t_ff;
   always_comb begin
      tw   = ab4_ff * p_ff;
      t_in = tw[48:24];
   end

   // L6: round
   logic [24:0] rnd;
   logic [16:0] lik_in, lik_ff;
   always_comb begin
      rnd    = t_ff + 25'd128;
      lik_in = l5_ff.inr ? rnd[24:8] : 17'd0;
   end

   lane_type l6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l1_ff  <= l1_in;
         l2_ff  <= l1_ff;
         l3_ff  <= l2_ff;
         l4_ff  <= l3_ff;
         l5_ff  <= l4_ff;
         l6_ff  <= l5_ff;
         u2_ff  <= u2_in;
         ab_ff  <= ab_in;
         u3_ff  <= u3_in;
         u2b_ff <= u2_ff;
         ab3_ff <= ab_ff;
         p_ff   <= p_in;
         ab4_ff <= ab3_ff;
         t_ff   <= t_in;
         lik_ff <= lik_in;
      end
   end

   assign out_valid  = v_ff[5];
   assign distance   = l6_ff.dval;
   assign likelihood = lik_ff;
   assign in_gate    = l6_ff.gin;
   assign singular   = l6_ff.sing;

endmodule

`default_nettype wire

// File: rtl/mahalanobis_gate_2d_top.sv
// ----------------------------------------------------------------------------
// mahalanobis_gate_2d_top
// Chi-square gating of one measurement against one predicted track in 2D.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one track/measurement pair per item; rsp_* returns one
//   item per pair with the squared Mahalanobis distance (Q16.16, saturating),
//   exp(-d/2) in Q1.16, the in-gate flag and the singular flag.
//   csr_* writes the noise variance (index 0) and gate threshold (index 1);
//   write only while no item is in flight.
// Throughput: one item per cycle, every cycle, when rsp_tready stays high.
// Pipeline: products and sums, then sixteen divider stages retiring two
//   quotient bits each, then likelihood evaluation.
// Stall: the whole pipeline freezes while a result sits unaccepted; req_tready
//   drops at the same time, so nothing is dropped or repeated and the next
//   item is taken as soon as the waiting result leaves.
// Reset: clears all valid bits and restores register defaults (noise 0.0225,
//   gate 16.0); the block accepts items in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mahalanobis_gate_2d_top (
   input  wire logic         clock,
   input  wire logic         reset,
   // track_x, track_y, cov_xx, cov_xy, cov_yx, cov_yy, meas_x, meas_y (32 each)
   input  wire logic [255:0] req_tdata,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // distance[31:0], likelihood[48:32], in_gate[49], singular[50], zero pad
   output logic [55:0]       rsp_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic [31:0]  csr_wdata
);

   logic [31:0] noise_ff, gate_ff;

   // take register writes; index 0 noise, index 1 gate
   always_ff @(posedge clock) begin
      if (reset) begin
         noise_ff <= mgd_pkg::NOISE_RESET;
         gate_ff  <= mgd_pkg::GATE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            mgd_pkg::REG_NOISE: noise_ff <= csr_wdata;
            mgd_pkg::REG_GATE:  gate_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // advance every stage unless a finished result is being held
   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   mgd_pkg::req_type req_item;
   assign req_item = req_tdata;

   logic             q_valid, d_valid;
   mgd_pkg::div_type q_item, d_item;

   mgd_quad u_quad (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .in_item   (req_item),
      .noise     (noise_ff),
      .out_valid (q_valid),
      .out_item  (q_item)
   );

   mgd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (q_valid),
      .in_item   (q_item),
      .out_valid (d_valid),
      .out_item  (d_item)
   );

   logic [31:0] distance;
   logic [16:0] likelihood;
   logic        in_gate, singular;

   mgd_lik u_lik (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (d_valid),
      .in_item    (d_item),
      .gate       (gate_ff),
      .out_valid  (rsp_tvalid),
      .distance   (distance),
      .likelihood (likelihood),
      .in_gate    (in_gate),
      .singular   (singular)
   );

   assign rsp_tdata = {5'd0, singular, in_gate, likelihood, distance};

   // singular result: saturated distance, zero likelihood, outside the gate
   a_singular: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && singular |-> distance == 32'hFFFFFFFF && likelihood == 17'd0 && !in_gate)
      else $error("singular result not saturated");

   a_lik_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> likelihood <= 17'd65536)
      else $error("likelihood above one");

   a_gate: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && in_gate |-> distance < gate_ff)
      else $error("in-gate flag with distance at or above threshold");

endmodule

`default_nettype wire

// File: verif/mahalanobis_gate_2d_top_tb.sv
// ----------------------------------------------------------------------------
// mahalanobis_gate_2d_top_tb
// Self-checking bench for the 2D Mahalanobis distance gate.
// Drives track/measurement pairs with random gaps and result stalls. Covers
// extreme, default and random noise and gate register settings in turn,
// and predicts distance, likelihood, in-gate and singular flags for each pair.
// ----------------------------------------------------------------------------
`default_nettype none

module mahalanobis_gate_2d_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mgd_pkg::*;

   localparam int          CYCLE_LIMIT = 2000000;
   localparam int          DRAIN_WAIT  = 40;     // beyond the pipeline latency
   localparam int          PHASE_ITEMS = 300;
   localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

   // exp(-i/2) and exp(-k/16) in Q1.24
   localparam int unsigned HALF_STEP[24] = '{
      16777216, 10175896, 6171993, 3743503, 2270549, 1377158,
      835288, 506628, 307285, 186378, 113044, 68565,
      41587, 25224, 15299, 9279, 5628, 3414,
      2070, 1256, 762, 462, 280, 170};
   localparam int unsigned SIXTEENTH_STEP[8] = '{
      16777216, 15760736, 14805841, 13908801,
      13066109, 12274473, 11530801, 10832185};

   typedef struct {
      logic [31:0] distance;
      logic [16:0] likelihood;
      logic        in_gate;
      logic        singular;
   } gate_result_t;

   // -------------------------------------------------------------------------
   // Scoreboard: gate predictor plus the queue of outstanding gate results
   // -------------------------------------------------------------------------
   class gate_scoreboard;
      logic [31:0]  noise_var;
      logic [31:0]  gate_thr;
      gate_result_t pending[$];
      int           errors;

      function new();
         noise_var = NOISE_RESET;
         gate_thr  = GATE_RESET;
         errors    = 0;
      endfunction

      function logic [16:0] exp_half_dist(logic [31:0] d);
         longint unsigned i, k, u, u2, u3, p, t;
         i = d[31:16];
         k = d[15:13];
         if (i >= 24) return 17'd0;
         u  = longint'(d[12:0]) << 7;
         u2 = (u * u) >> 24;
         u3 = (u2 * u) >> 24;
         p  = 64'd16777216 - u + (u2 >> 1) - u3 / 6;
         t  = (longint'(HALF_STEP[i]) * longint'(SIXTEENTH_STEP[k])) >> 24;
         t  = (t * p) >> 24;
         return 17'((t + 128) >> 8);
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function gate_result_t gate_pair(req_type r);
         logic signed [127:0] rx, ry, sxx, syy, sxy, syx, det, quad;
         logic [139:0]        num, den, quo;
         gate_result_t        e;
         rx  = longint'(r.meas_x) - longint'(r.track_x);
         ry  = longint'(r.meas_y) - longint'(r.track_y);
         sxx = clamp32(longint'(r.cov_xx) + longint'(noise_var));
         syy = clamp32(longint'(r.cov_yy) + longint'(noise_var));
         sxy = longint'(r.cov_xy);
         syx = longint'(r.cov_yx);
         det  = sxx * syy - sxy * syx;
         quad = syy * rx * rx - (sxy + syx) * rx * ry + sxx * ry * ry;
         e.distance = ALL_ONES;
         e.singular = (det <= 0);
         // negative quadratic form keeps the saturated distance
         if (!e.singular && quad >= 0) begin
            num = quad;
            num = num << 8;
            den = det;
            quo = num / den;
            e.distance = (quo > 140'(ALL_ONES)) ? ALL_ONES : quo[31:0];
         end
         e.likelihood = exp_half_dist(e.distance);
         e.in_gate    = !e.singular && (e.distance < gate_thr);
         return e;
      endfunction

      function void note_pair(req_type r);
         pending.push_back(gate_pair(r));
      endfunction

      function void check_result(logic [55:0] d);
         gate_result_t e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", d);
            return;
         end
         e = pending.pop_front();
         if (d[31:0] !== e.distance || d[48:32] !== e.likelihood ||
             d[49] !== e.in_gate || d[50] !== e.singular) begin
            errors++;
            if (errors <= 10)
               $display("mismatch dist %h/%h lik %h/%h gate %b/%b sing %b/%b (exp/act)",
                        e.distance, d[31:0], e.likelihood, d[48:32],
                        e.in_gate, d[49], e.singular, d[50]);
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [255:0] req_tdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [55:0]  rsp_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic         csr_we = 1'b0;
   logic         csr_index = REG_NOISE;
   logic [31:0]  csr_wdata = '0;

   gate_scoreboard sb = new();
   bit  no_idle = 1'b0;       // both sides run gap-free while set
   bit  hold_request = 1'b0;  // receiver holds off for a long stretch
   int  cycles = 0;

   mahalanobis_gate_2d_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Sample both handshakes at the rising edge, before any output update.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_pair(req_type'(req_tdata));
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Result side: random stalls, with one long hold-off on request.
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (300) @(negedge clock);
         end
         gap = no_idle ? 0 : $urandom_range(0, 14);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   function automatic req_type make_pair(int tx, int ty, int cxx, int cxy, int cyx,
                                         int cyy, int mx, int my);
      req_type r;
      r.track_x = tx;  r.track_y = ty;
      r.cov_xx  = cxx; r.cov_xy  = cxy;
      r.cov_yx  = cyx; r.cov_yy  = cyy;
      r.meas_x  = mx;  r.meas_y  = my;
      return r;
   endfunction

   // Mostly well-conditioned pairs near the gate; else noise, corners, det 0, asymmetric.
   function automatic req_type random_pair();
      req_type r;
      int      tx, ty, off;
      int      corner[5];
      corner = '{0, 1, -1, 32'sh7FFF_FFFF, 32'sh8000_0000};
      tx  = int'($urandom_range(0, 1 << 26)) - (1 << 25);
      ty  = int'($urandom_range(0, 1 << 26)) - (1 << 25);
      off = int'($urandom_range(0, 1 << 24)) - (1 << 23);
      r = make_pair(tx, ty, $urandom_range(0, 1 << 26), off, off,
                    $urandom_range(0, 1 << 26),
                    tx + int'($urandom_range(0, 1 << 20)) - (1 << 19),
                    ty + int'($urandom_range(0, 1 << 20)) - (1 << 19));
      case ($urandom_range(0, 9))
         6: r = req_type'({$urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom});
         7: begin
            // cancel the noise so the determinant collapses
            r.cov_xx = -int'(sb.noise_var);
            r.cov_xy = 0;
         end
         8: begin
            r.cov_xx = corner[$urandom_range(0, 4)];
            r.cov_yy = corner[$urandom_range(0, 4)];
            r.meas_x = corner[$urandom_range(0, 4)];
            r.track_y = corner[$urandom_range(0, 4)];
         end
         9: r.cov_yx = r.cov_xy + int'($urandom_range(0, 1 << 22)) - (1 << 21);
         default: ;
      endcase
      return r;
   endfunction

   // Offer one pair after a random gap; hold valid across back-to-back pairs.
   task automatic send_pair(req_type r);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= r;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Stop offering and wait until every predicted result has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == REG_NOISE) sb.noise_var = value;
      else sb.gate_thr = value;
   endtask

   task automatic run_phase(logic [31:0] noise, logic [31:0] gate, bit with_hold);
      drain();
      write_csr(REG_NOISE, noise);
      write_csr(REG_GATE, gate);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (with_hold && n == 20) begin
            // keep offering gap-free while the receiver holds off
            no_idle = 1'b1;
            hold_request = 1'b1;
         end
         if (with_hold && n == 150) no_idle = 1'b0;
         if (n == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 0) no_idle = !no_idle;
         send_pair(random_pair());
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed pairs under the reset register values.
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));                 // zero distance
      send_pair(make_pair(0, 0, 1 << 24, 0, 0, 1 << 24, 1 << 16, 0));
      send_pair(make_pair(0, 0, 1 << 24, 0, 0, 1 << 24, 4 << 16, 0));  // just inside the gate
      send_pair(make_pair(0, 0, 1 << 24, 0, 0, 1 << 24, 7 << 16, 0));  // past 24.0
      send_pair(make_pair(0, 0, -377487, 0, 0, 1 << 24, 5, 5));        // zero determinant
      send_pair(make_pair(0, 0, 1 << 24, 1 << 25, 1 << 25, 1 << 24, 1, 1)); // negative det
      send_pair(make_pair(0, 0, -(1 << 28), 0, 0, -(1 << 28), 1 << 16, 0)); // negative form
      send_pair(make_pair(32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 0,
                          32'sh7FFF_FFFF, 32'sh7FFF_FFFF));             // overflow
      send_pair(make_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0,
                          32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000));
      send_pair(make_pair(0, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                          32'sh8000_0000, -1, -1));
      send_pair(make_pair(0, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                          32'sh8000_0000, 1, -1));
      send_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
      send_pair(make_pair(1, -1, 1 << 20, 1 << 19, -(1 << 19), 1 << 21,
                          3 << 14, -(5 << 14)));                        // asymmetric
      send_pair(make_pair(100 << 16, -(50 << 16), 1 << 26, 1 << 23, 1 << 23, 1 << 25,
                          101 << 16, -(49 << 16)));

      // Register extremes, random settings, defaults again; pauses in between.
      run_phase(32'd0, 32'd0, 1'b0);
      run_phase(ALL_ONES, ALL_ONES, 1'b1);
      run_phase($urandom, $urandom, 1'b0);
      run_phase($urandom_range(0, 1 << 26), $urandom_range(0, 64 << 16), 1'b1);
      run_phase(NOISE_RESET, GATE_RESET, 1'b0);
      run_phase($urandom_range(1, 1 << 22), $urandom_range(1 << 16, 32 << 16), 1'b0);

      drain();
      sb.errors += sb.pending.size();
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
